/* src/sfcs_pkg.sv */
`default_nettype none
package sfcs_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MODE      = 1'b0;
  localparam logic CFG_START_FWD = 1'b1;

  // Cycle modes (code 7 runs as loop)
  localparam logic [2:0] MODE_LOOP      = 3'd0;
  localparam logic [2:0] MODE_END       = 3'd1;
  localparam logic [2:0] MODE_END_BACK  = 3'd2;
  localparam logic [2:0] MODE_END_FWD   = 3'd3;
  localparam logic [2:0] MODE_FWD_BACK  = 3'd4;
  localparam logic [2:0] MODE_PING_PONG = 3'd5;
  localparam logic [2:0] MODE_START_RST = 3'd6;

  // One table entry as stored in the entry memory
  typedef struct packed {
    logic        chg;
    logic [7:0]  frame;
    logic [7:0]  last;
    logic [15:0] speed;
    logic [31:0] due;
  } sfcs_entry_t;

  // Outcome of one frame step
  typedef struct packed {
    logic [7:0] frame;
    logic       fwd;
    logic       inc;
  } sfcs_step_t;

  // One result item
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] frame;
    logic       chg;
    logic [4:0] total;
    logic       full;
    logic       fin;
    logic       last;
  } sfcs_out_t;

endpackage
`default_nettype wire

/* src/sprite_frame_cycle_sequencer.sv */
// Add, start, stop and a tick while not cycling or with an empty table: one result
// in the output register in the cycle after the input transfer; next transfer once that result is taken.
// Tick while cycling over n entries: read-modify-write walk of the entry memory, then
// read-out at one result per cycle while the output is taken; next transfer once the
// last result is taken.
// Reset (rst_n low, synchronous): empty table, cycling off, forward, register defaults.
`default_nettype none
module sprite_frame_cycle_sequencer #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [2:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [31:0] in_now_ticks,
  input  wire logic [7:0]  in_entry_frame,
  input  wire logic [7:0]  in_entry_last_frame,
  input  wire logic [15:0] in_entry_speed,
  input  wire logic        in_start_when_first,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_entry_index,
  output logic [7:0]       out_frame_now,
  output logic             out_frame_changed,
  output logic [4:0]       out_entry_total,
  output logic             out_table_full,
  output logic             out_all_finished,
  output logic             out_last_result
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // count to 4-bit slot index (low bits)
  function automatic logic [3:0] to_idx4(input logic [CNT_W-1:0] v);
    logic [CNT_W+3:0] e;
    e = {4'b0, v};
    return e[3:0];
  endfunction

  // count to 5-bit total (low bits)
  function automatic logic [4:0] to_tot5(input logic [CNT_W-1:0] v);
    logic [CNT_W+4:0] e;
    e = {5'b0, v};
    return e[4:0];
  endfunction

  // clamp to the 0..255 frame range
  function automatic logic [7:0] fit8(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // next frame of one entry by cycle mode
  function automatic sfcs_pkg::sfcs_step_t next_step(input logic [7:0] cel,
                                                     input logic [7:0] lst,
                                                     input logic       fwd,
                                                     input logic [2:0] mode);
    sfcs_pkg::sfcs_step_t s;
    logic signed [9:0] c;
    logic signed [9:0] l;
    logic signed [9:0] d;
    logic signed [9:0] n;
    logic              f2;
    c = signed'({2'b00, cel});
    l = signed'({2'b00, lst});
    d = fwd ? 10'sd1 : -10'sd1;
    s.fwd = fwd;
    s.inc = 1'b0;
    n = c + d;
    f2 = fwd;
    unique case (mode)
      sfcs_pkg::MODE_END: begin
        if (n < 0) begin
          n = 10'sd0;
          s.inc = 1'b1;
        end else if (n > l) begin
          n = l;
          s.inc = 1'b1;
        end
      end
      sfcs_pkg::MODE_END_BACK: begin
        s.fwd = 1'b0;
        if (c == 10'sd0) begin
          s.inc = 1'b1;
          n = 10'sd0;
        end else begin
          n = c - 10'sd1;
        end
      end
      sfcs_pkg::MODE_END_FWD: begin
        if (c >= l) begin
          s.inc = 1'b1;
          n = c;
        end
      end
      sfcs_pkg::MODE_FWD_BACK: begin
        if (c == 10'sd0 && !fwd) begin
          s.inc = 1'b1;
          s.fwd = 1'b1;
          n = c;
        end else if (c == l) begin
          s.fwd = 1'b0;
          n = c - 10'sd1;
        end
      end
      sfcs_pkg::MODE_PING_PONG: begin
        if (l != 10'sd0) begin
          if (c == 10'sd0) begin
            f2 = 1'b1;
          end else if (c == l) begin
            f2 = 1'b0;
          end
          s.fwd = f2;
          n = c + (f2 ? 10'sd1 : -10'sd1);
        end else begin
          n = c;
        end
      end
      sfcs_pkg::MODE_START_RST: begin
        if (c == 10'sd0) begin
          s.inc = 1'b1;
          n = l;
        end else begin
          s.fwd = 1'b0;
          n = c - 10'sd1;
        end
      end
      default: begin
        // loop: wrap at both ends
        if (n < 0) begin
          n = l;
        end else if (n > l) begin
          n = 10'sd0;
        end
      end
    endcase
    s.frame = fit8(n);
    return s;
  endfunction

  // entry memory
  sfcs_pkg::sfcs_entry_t mem [MAX_ENTRIES];
  sfcs_pkg::sfcs_entry_t mem_q;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  sfcs_pkg::sfcs_entry_t wr_data;

  // control and state registers
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mfwd_r, mfwd_nxt;
  logic             cyc_r, cyc_nxt;
  logic [CNT_W-1:0] comp_r, comp_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic             pend_r, pend_nxt;
  logic             fin_r, fin_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [2:0]       mode_r;
  logic             sfwd_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  sfcs_pkg::sfcs_out_t   out_r, out_nxt;

  logic                  out_free;
  logic                  due_ok;
  logic [31:0]           lag;
  logic [31:0]           new_due;
  sfcs_pkg::sfcs_step_t  step;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;

  // timer re-arm: now + (speed - lag) equals due + speed while lag < speed
  assign due_ok  = now_r >= mem_q.due;
  assign lag     = now_r - mem_q.due;
  assign new_due = (lag >= {16'b0, mem_q.speed}) ? now_r : mem_q.due + {16'b0, mem_q.speed};
  assign step    = next_step(mem_q.frame, mem_q.last, mfwd_r, mode_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mfwd_nxt      = mfwd_r;
    cyc_nxt       = cyc_r;
    comp_nxt      = comp_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    cur_nxt       = cur_r;
    pend_nxt      = pend_r;
    fin_nxt       = fin_r;
    now_nxt       = now_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = mem_q;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{idx: 4'd0, frame: 8'd0, chg: 1'b0, total: to_tot5(count_r),
                            full: 1'b0, fin: 1'b0, last: 1'b1};
          unique case (in_operation)
            sfcs_pkg::OP_ADD: begin
              if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                out_nxt.full = 1'b1;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = count_r[IDX_W-1:0];
                wr_data.chg   = 1'b0;
                wr_data.frame = in_entry_frame;
                wr_data.last  = in_entry_last_frame;
                wr_data.speed = in_entry_speed;
                wr_data.due   = in_now_ticks + {16'b0, in_entry_speed};
                count_nxt     = count_r + CNT_W'(1);
                if (count_r == '0 && in_start_when_first) begin
                  cyc_nxt  = 1'b1;
                  mfwd_nxt = sfwd_r;
                end
                out_nxt.idx   = to_idx4(count_r);
                out_nxt.frame = in_entry_frame;
                out_nxt.total = to_tot5(count_nxt);
              end
            end
            sfcs_pkg::OP_TICK: begin
              if (cyc_r && count_r == '0) begin
                // empty table finishes at once
                cyc_nxt     = 1'b0;
                out_nxt.fin = 1'b1;
              end else if (cyc_r) begin
                // start the walk: read slot 0
                out_valid_nxt = out_valid_r && !out_ready;
                out_nxt       = out_r;
                rd_en         = 1'b1;
                rd_addr       = '0;
                cur_nxt       = '0;
                rd_cnt_nxt    = CNT_W'(1);
                pend_nxt      = 1'b1;
                comp_nxt      = '0;
                n_nxt         = count_r;
                now_nxt       = in_now_ticks;
                state_nxt     = ST_WALK;
              end
            end
            sfcs_pkg::OP_START: begin
              cyc_nxt  = 1'b1;
              mfwd_nxt = sfwd_r;
            end
            default: begin
              cyc_nxt = 1'b0;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (pend_r) begin
          // write back the entry read last cycle, read the next one
          wr_en   = 1'b1;
          wr_addr = cur_r[IDX_W-1:0];
          if (due_ok) begin
            wr_data.chg   = 1'b1;
            wr_data.frame = step.frame;
            wr_data.due   = new_due;
            mfwd_nxt      = step.fwd;
            comp_nxt      = comp_r + CNT_W'(step.inc);
          end else begin
            wr_data.chg = 1'b0;
          end
          if (rd_cnt_r < n_r) begin
            rd_en      = 1'b1;
            rd_addr    = rd_cnt_r[IDX_W-1:0];
            cur_nxt    = rd_cnt_r;
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            pend_nxt = 1'b0;
          end
        end else begin
          // walk done: settle finish, then read out from slot 0
          fin_nxt = (comp_r == n_r);
          if (comp_r == n_r) begin
            cyc_nxt   = 1'b0;
            count_nxt = '0;
          end
          rd_en      = 1'b1;
          rd_addr    = '0;
          cur_nxt    = '0;
          rd_cnt_nxt = CNT_W'(1);
          state_nxt  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{idx: to_idx4(cur_r), frame: mem_q.frame, chg: mem_q.chg,
                            total: to_tot5(count_r), full: 1'b0, fin: fin_r,
                            last: (rd_cnt_r == n_r)};
          if (rd_cnt_r < n_r) begin
            rd_en      = 1'b1;
            rd_addr    = rd_cnt_r[IDX_W-1:0];
            cur_nxt    = rd_cnt_r;
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // entry memory: registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mfwd_r      <= 1'b1;
      cyc_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mfwd_r      <= mfwd_nxt;
      cyc_r       <= cyc_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk bookkeeping and result payload
  always_ff @(posedge clk) begin
    comp_r   <= comp_nxt;
    n_r      <= n_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    cur_r    <= cur_nxt;
    fin_r    <= fin_nxt;
    now_r    <= now_nxt;
    out_r    <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sfcs_pkg::MODE_LOOP;
      sfwd_r <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == sfcs_pkg::CFG_MODE) begin
        mode_r <= cfg_data;
      end else begin
        sfwd_r <= cfg_data[0];
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_index   = out_r.idx;
  assign out_frame_now     = out_r.frame;
  assign out_frame_changed = out_r.chg;
  assign out_entry_total   = out_r.total;
  assign out_table_full    = out_r.full;
  assign out_all_finished  = out_r.fin;
  assign out_last_result   = out_r.last;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;

  localparam int          SLOTS        = 16;
  localparam int          RANDOM_ITEMS = 400;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_TICKS  = 24;
  localparam logic [2:0]  MODE_SPARE   = 3'd7;   // unused code, runs as loop

  // one input transfer
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [7:0]  frame;
    logic [7:0]  last;
    logic [15:0] speed;
    logic        swf;
  } seq_item_t;

  // one row of the directed plan: a register write or an item
  typedef struct packed {
    logic                is_cfg;
    logic                cfg_idx;
    logic [2:0]          cfg_val;
    seq_item_t           item;
    logic                has_exp;
    sfcs_pkg::sfcs_out_t exp_res;
  } plan_row_t;

  logic        clk;
  logic        rst_n               = 1'b0;
  logic        cfg_we              = 1'b0;
  logic        cfg_index           = 1'b0;
  logic [2:0]  cfg_data            = 3'd0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation        = sfcs_pkg::OP_ADD;
  logic [31:0] in_now_ticks        = 32'd0;
  logic [7:0]  in_entry_frame      = 8'd0;
  logic [7:0]  in_entry_last_frame = 8'd0;
  logic [15:0] in_entry_speed      = 16'd0;
  logic        in_start_when_first = 1'b0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [3:0]  out_entry_index;
  logic [7:0]  out_frame_now;
  logic        out_frame_changed;
  logic [4:0]  out_entry_total;
  logic        out_table_full;
  logic        out_all_finished;
  logic        out_last_result;

  sprite_frame_cycle_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_now_ticks        (in_now_ticks),
    .in_entry_frame      (in_entry_frame),
    .in_entry_last_frame (in_entry_last_frame),
    .in_entry_speed      (in_entry_speed),
    .in_start_when_first (in_start_when_first),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_entry_index     (out_entry_index),
    .out_frame_now       (out_frame_now),
    .out_frame_changed   (out_frame_changed),
    .out_entry_total     (out_entry_total),
    .out_table_full      (out_table_full),
    .out_all_finished    (out_all_finished),
    .out_last_result     (out_last_result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sequencer state as predicted
  logic [7:0]  seq_frame [SLOTS];
  logic [7:0]  seq_last  [SLOTS];
  logic [15:0] seq_speed [SLOTS];
  logic [31:0] seq_due   [SLOTS];
  int unsigned seq_used      = 0;
  logic        seq_fwd       = 1'b1;
  logic        seq_running   = 1'b0;
  logic [2:0]  seq_mode      = sfcs_pkg::MODE_LOOP;
  logic        seq_start_fwd = 1'b1;
  int unsigned cycles_done   = 0;

  sfcs_pkg::sfcs_out_t step_res[$];     // results of the item just predicted
  sfcs_pkg::sfcs_out_t pending_res[$];  // results still owed by the block

  int tx_idle = 15;
  int rx_idle = 69;
  int n_items = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_finished = 0;
  int n_refused = 0;
  logic [31:0] tick_clock = 32'd0;

  function automatic logic [7:0] clamp_frame(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // next frame of one slot under the current cycle mode
  function automatic logic [7:0] advance_frame(int slot);
    int cel;
    int lst;
    int n;
    cel = seq_frame[slot];
    lst = seq_last[slot];
    case (seq_mode)
      sfcs_pkg::MODE_END: begin
        n = cel + (seq_fwd ? 1 : -1);
        if (n < 0) begin
          n = 0;
          cycles_done++;
        end
        if (n > lst) begin
          n = lst;
          cycles_done++;
        end
        return clamp_frame(n);
      end
      sfcs_pkg::MODE_END_BACK: begin
        seq_fwd = 1'b0;
        if (cel == 0) begin
          cycles_done++;
          return 8'd0;
        end
        return clamp_frame(cel - 1);
      end
      sfcs_pkg::MODE_END_FWD: begin
        if (cel >= lst) begin
          cycles_done++;
          return clamp_frame(cel);
        end
        return clamp_frame(cel + (seq_fwd ? 1 : -1));
      end
      sfcs_pkg::MODE_FWD_BACK: begin
        if (cel == 0 && !seq_fwd) begin
          cycles_done++;
          seq_fwd = 1'b1;
        end else if (cel == lst) begin
          seq_fwd = 1'b0;
          cel = cel - 1;
        end else begin
          cel = cel + (seq_fwd ? 1 : -1);
        end
        return clamp_frame(cel);
      end
      sfcs_pkg::MODE_PING_PONG: begin
        if (lst != 0) begin
          if (cel == 0) seq_fwd = 1'b1;
          else if (cel == lst) seq_fwd = 1'b0;
          return clamp_frame(cel + (seq_fwd ? 1 : -1));
        end
        return clamp_frame(cel);
      end
      sfcs_pkg::MODE_START_RST: begin
        if (cel == 0) begin
          cycles_done++;
          return clamp_frame(lst);
        end
        seq_fwd = 1'b0;
        return clamp_frame(cel - 1);
      end
      default: begin
        n = cel + (seq_fwd ? 1 : -1);
        if (n < 0) n = lst;
        else if (n > lst) n = 0;
        return clamp_frame(n);
      end
    endcase
  endfunction

  // update the predicted state for one item and collect its results
  function automatic void apply_item(seq_item_t it);
    sfcs_pkg::sfcs_out_t r;
    int unsigned         slot;
    int unsigned         cnt;
    logic [31:0]         lag;
    logic [31:0]         hold;
    logic [SLOTS-1:0]    stepped;
    logic                fin;
    step_res.delete();
    r = '0;
    case (it.op)
      sfcs_pkg::OP_ADD: begin
        if (seq_used >= SLOTS) begin
          r.total = 5'(seq_used);
          r.full  = 1'b1;
        end else begin
          slot = seq_used;
          seq_frame[slot] = it.frame;
          seq_last[slot]  = it.last;
          seq_speed[slot] = it.speed;
          seq_due[slot]   = it.now + 32'(it.speed);
          seq_used = slot + 1;
          if (seq_used == 1 && it.swf) begin
            seq_running = 1'b1;
            seq_fwd = seq_start_fwd;
          end
          r.idx   = 4'(slot);
          r.frame = it.frame;
          r.total = 5'(seq_used);
        end
        step_res = {step_res, r};
      end
      sfcs_pkg::OP_TICK: begin
        if (!seq_running) begin
          r.total = 5'(seq_used);
          step_res = {step_res, r};
        end else begin
          cycles_done = 0;
          stepped = '0;
          for (int i = 0; i < seq_used; i++) begin
            if (it.now >= seq_due[i]) begin
              lag  = it.now - seq_due[i];
              hold = (lag >= seq_speed[i]) ? 32'd0 : seq_speed[i] - lag;
              seq_due[i] = it.now + hold;
              seq_frame[i] = advance_frame(i);
              stepped[i] = 1'b1;
            end
          end
          fin = (cycles_done == seq_used);
          cnt = seq_used;
          if (fin) begin
            seq_running = 1'b0;
            seq_used = 0;
          end
          for (int i = 0; i < cnt; i++) begin
            r.idx   = 4'(i);
            r.frame = seq_frame[i];
            r.chg   = stepped[i];
            r.total = 5'(seq_used);
            r.fin   = fin;
            step_res = {step_res, r};
          end
          if (cnt == 0) begin
            r.total = 5'(seq_used);
            r.fin   = fin;
            step_res = {step_res, r};
          end
        end
      end
      sfcs_pkg::OP_START: begin
        seq_running = 1'b1;
        seq_fwd = seq_start_fwd;
        r.total = 5'(seq_used);
        step_res = {step_res, r};
      end
      default: begin
        seq_running = 1'b0;
        r.total = 5'(seq_used);
        step_res = {step_res, r};
      end
    endcase
    r = step_res.pop_back();
    r.last = 1'b1;
    step_res = {step_res, r};
  endfunction

  function automatic seq_item_t mk_item(logic [1:0] op, logic [31:0] now, logic [7:0] fr,
                                        logic [7:0] lst, logic [15:0] spd, logic swf);
    seq_item_t it;
    it.op = op;
    it.now = now;
    it.frame = fr;
    it.last = lst;
    it.speed = spd;
    it.swf = swf;
    return it;
  endfunction

  // single closing result with no step flag
  function automatic sfcs_pkg::sfcs_out_t res(logic [3:0] idx, logic [7:0] fr,
                                              logic [4:0] total, logic full, logic fin);
    sfcs_pkg::sfcs_out_t r;
    r = '0;
    r.idx = idx;
    r.frame = fr;
    r.total = total;
    r.full = full;
    r.fin = fin;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t op_row(seq_item_t it, logic has, sfcs_pkg::sfcs_out_t e);
    plan_row_t p;
    p = '0;
    p.item = it;
    p.has_exp = has;
    p.exp_res = e;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic idx, logic [2:0] val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = val;
    return p;
  endfunction

  // drive one item, wait for its transfer, then queue what it must produce
  task automatic send_item(seq_item_t it, logic has_exp, sfcs_pkg::sfcs_out_t typed);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= it.op;
    in_now_ticks        <= it.now;
    in_entry_frame      <= it.frame;
    in_entry_last_frame <= it.last;
    in_entry_speed      <= it.speed;
    in_start_when_first <= it.swf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(it);
    if (step_res[0].fin) n_finished++;
    if (step_res[0].full) n_refused++;
    if (has_exp) pending_res = {pending_res, typed};
    else pending_res = {pending_res, step_res};
    n_items++;
    @(negedge clk);
  endtask

  // hold the sender until every owed result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [2:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == sfcs_pkg::CFG_MODE) seq_mode = val;
    else seq_start_fwd = val[0];
  endtask

  // end-back mode with every entry due walks all frames down to zero; a bounded
  // number of ticks per call, a later call picks up what is left
  task automatic drain_table();
    logic [31:0] latest;
    int          left;
    left = DRAIN_TICKS;
    write_reg(sfcs_pkg::CFG_MODE, sfcs_pkg::MODE_END_BACK);
    send_item(mk_item(sfcs_pkg::OP_START, 32'd0, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
    while (seq_used != 0 && left > 0) begin
      latest = 32'd0;
      for (int i = 0; i < seq_used; i++)
        if (seq_due[i] > latest) latest = seq_due[i];
      send_item(mk_item(sfcs_pkg::OP_TICK, latest, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
      left--;
    end
  endtask

  // fill the table, start cycling and tick it, with some noise mixed in
  task automatic play_sequence();
    seq_item_t it;
    int n;
    if (seq_used != 0 && $urandom_range(0, 3) != 0) drain_table();
    write_reg(sfcs_pkg::CFG_MODE, 3'($urandom_range(0, 7)));
    write_reg(sfcs_pkg::CFG_START_FWD, 3'($urandom_range(0, 1)));
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      it.op    = sfcs_pkg::OP_ADD;
      it.now   = tick_clock;
      it.frame = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 7));
      it.last  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 7));
      it.speed = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 8));
      it.swf   = 1'($urandom_range(0, 1));
      tick_clock += 32'($urandom_range(0, 3));
      send_item(it, 1'b0, '0);
    end
    if (!seq_running)
      send_item(mk_item(sfcs_pkg::OP_START, tick_clock, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
    n = $urandom_range(2, 16);
    for (int k = 0; k < n && seq_used != 0; k++) begin
      tick_clock += ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 70000))
                                                : 32'($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) begin
        send_item(mk_item(sfcs_pkg::OP_STOP, tick_clock, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
        if ($urandom_range(0, 1) == 0)
          send_item(mk_item(sfcs_pkg::OP_TICK, tick_clock, 8'd0, 8'd0, 16'd0, 1'b0),
                    1'b0, '0);
        send_item(mk_item(sfcs_pkg::OP_START, tick_clock, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
      end
      send_item(mk_item(sfcs_pkg::OP_TICK, tick_clock, 8'd0, 8'd0, 16'd0, 1'b0), 1'b0, '0);
    end
    // noise: any operation with any field values
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        it.op    = 2'($urandom_range(0, 3));
        it.now   = $urandom;
        it.frame = 8'($urandom);
        it.last  = 8'($urandom);
        it.speed = 16'($urandom);
        it.swf   = 1'($urandom);
        send_item(it, 1'b0, '0);
      end
    end
  endtask

  // result receiver: random stalls
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle);

  // result check
  always @(posedge clk) begin : check_results
    sfcs_pkg::sfcs_out_t got;
    sfcs_pkg::sfcs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      got.idx   = out_entry_index;
      got.frame = out_frame_now;
      got.chg   = out_frame_changed;
      got.total = out_entry_total;
      got.full  = out_table_full;
      got.fin   = out_all_finished;
      got.last  = out_last_result;
      n_results++;
      if (pending_res.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected i=%0d fr=%0d ch=%0b tot=%0d full=%0b fin=%0b last=%0b",
                   $realtime, got.idx, got.frame, got.chg, got.total, got.full, got.fin,
                   got.last);
      end else begin
        want = pending_res.pop_front();
        if (got.idx !== want.idx || got.frame !== want.frame || got.chg !== want.chg ||
            got.total !== want.total || got.full !== want.full || got.fin !== want.fin ||
            got.last !== want.last) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("%0t: exp i=%0d fr=%0d ch=%0b tot=%0d full=%0b fin=%0b last=%0b",
                     $realtime, want.idx, want.frame, want.chg, want.total, want.full,
                     want.fin, want.last);
            $display("%0t: got i=%0d fr=%0d ch=%0b tot=%0d full=%0b fin=%0b last=%0b",
                     $realtime, got.idx, got.frame, got.chg, got.total, got.full,
                     got.fin, got.last);
          end
        end
      end
    end
  end

  // watchdog: too long without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    plan_row_t plan[$];
    int goal;

    // directed plan: idle ticks, empty-table finish, table fill and overflow,
    // wrapped due time, spare mode code, backward start in ping-pong
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_TICK, 32'd0, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd0, 8'd0, 5'd0, 1'b0, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_STOP, 32'd0, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd0, 8'd0, 5'd0, 1'b0, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_START, 32'd0, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd0, 8'd0, 5'd0, 1'b0, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_TICK, 32'd5, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd0, 8'd0, 5'd0, 1'b0, 1'b1))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_ADD, 32'hFFFF_FFFF, 8'd255, 8'd255, 16'hFFFF,
                                 1'b1), 1'b1, res(4'd0, 8'd255, 5'd1, 1'b0, 1'b0))};
    for (int s = 1; s < 15; s++)
      plan = {plan, op_row(mk_item(sfcs_pkg::OP_ADD, 32'(s), 8'(s * 17), 8'(s * 23),
                                   16'((s - 1) * 1000), 1'(s)), 1'b0, '0)};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_ADD, 32'd16, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd15, 8'd0, 5'd16, 1'b0, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_ADD, 32'd17, 8'hAA, 8'h55, 16'h5555, 1'b1),
                         1'b1, res(4'd0, 8'd0, 5'd16, 1'b1, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_TICK, 32'h0000_FFFE, 8'd0, 8'd0, 16'd0, 1'b0),
                         1'b0, '0)};
    plan = {plan, cfg_row(sfcs_pkg::CFG_MODE, MODE_SPARE)};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_TICK, 32'h0002_0000, 8'd0, 8'd0, 16'd0, 1'b0),
                         1'b0, '0)};
    plan = {plan, cfg_row(sfcs_pkg::CFG_MODE, sfcs_pkg::MODE_PING_PONG)};
    plan = {plan, cfg_row(sfcs_pkg::CFG_START_FWD, 3'd0)};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_START, 32'd0, 8'd0, 8'd0, 16'd0, 1'b0), 1'b1,
                         res(4'd0, 8'd0, 5'd16, 1'b0, 1'b0))};
    plan = {plan, op_row(mk_item(sfcs_pkg::OP_TICK, 32'h0004_0000, 8'd0, 8'd0, 16'd0, 1'b0),
                         1'b0, '0)};

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      else send_item(plan[i].item, plan[i].has_exp, plan[i].exp_res);
    end

    // random part in three idling profiles
    tick_clock = 32'h0010_0000;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 15 : (ph == 1) ? 69 : 0;
      rx_idle = (ph == 0) ? 69 : (ph == 1) ? 15 : 0;
      goal = n_items + RANDOM_ITEMS / 3;
      while (n_items < goal) play_sequence();
    end

    // drain and settle
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run: %0d items in, %0d results out, %0d finishing ticks, %0d refused adds",
             n_items, n_results, n_finished, n_refused);
    $display("  random modes and directions under three stall profiles; %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0 && pending_res.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
src/sfcs_pkg.sv
src/sprite_frame_cycle_sequencer.sv
tb/tb_top.sv
